@@ hdl/drvs_pkg.sv @@
package drvs_pkg;

   localparam int VOLT_W    = 21;
   localparam int SLEW_W    = 16;
   localparam int SETTLE_W  = 10;
   localparam int CSR_IDX_W = 3;
   localparam int DIV_CNT_W = $clog2(VOLT_W);

   localparam logic [VOLT_W-1:0]   WAIT_SAT          = 21'd2000000;
   localparam logic                RST_SUPPLY        = 1'b1;
   localparam logic [VOLT_W-1:0]   RST_TRANS_UV      = 21'd750000;
   localparam logic [VOLT_W-1:0]   RST_TRANS_NEXT_UV = 21'd825000;
   localparam logic [VOLT_W-1:0]   RST_CORE_FLOOR_UV = 21'd0;
   localparam logic [SLEW_W-1:0]   RST_SLEW_UP       = 16'd10000;
   localparam logic [SLEW_W-1:0]   RST_SLEW_DOWN     = 16'd5000;
   localparam logic [SETTLE_W-1:0] RST_SETTLE_US     = 10'd8;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SUPPLY_PRESENT = 3'd0,
      CSR_TRANS_UV       = 3'd1,
      CSR_TRANS_NEXT_UV  = 3'd2,
      CSR_CORE_FLOOR_UV  = 3'd3,
      CSR_SLEW_UP        = 3'd4,
      CSR_SLEW_DOWN      = 3'd5,
      CSR_SETTLE_BASE_US = 3'd6
   } csr_idx_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PLAN,
      ST_LOAD,
      ST_START,
      ST_DIV,
      ST_OUT
   } ctl_state_type;

   typedef enum logic [1:0] {
      STEP_PRE,
      STEP_SUP,
      STEP_CORE
   } step_type;

   typedef struct packed {
      logic                supply_present;
      logic [VOLT_W-1:0]   trans_uv;
      logic [VOLT_W-1:0]   trans_next_uv;
      logic [VOLT_W-1:0]   core_floor_uv;
      logic [SLEW_W-1:0]   slew_up;
      logic [SLEW_W-1:0]   slew_down;
      logic [SETTLE_W-1:0] settle_base_us;
   } cfg_type;

   typedef struct packed {
      logic              start;
      logic [VOLT_W-1:0] dividend;
      logic [SLEW_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [VOLT_W-1:0] quot;
      logic              rem_nz;
   } div_rsp_type;

endpackage

@@ hdl/drvs_if.sv @@
interface drvs_req_if;
   import drvs_pkg::*;
   logic              valid;
   logic              ready;
   logic [VOLT_W-1:0] target_min_uv;
   logic [VOLT_W-1:0] target_max_uv;
   modport source (output valid, target_min_uv, target_max_uv, input ready);
   modport sink (input valid, target_min_uv, target_max_uv, output ready);
endinterface

interface drvs_rsp_if;
   import drvs_pkg::*;
   logic              valid;
   logic              ready;
   logic              rail;
   logic [VOLT_W-1:0] volt_min_uv;
   logic [VOLT_W-1:0] volt_max_uv;
   logic [VOLT_W-1:0] wait_us;
   logic              last;
   modport source (output valid, rail, volt_min_uv, volt_max_uv, wait_us, last, input ready);
   modport sink (input valid, rail, volt_min_uv, volt_max_uv, wait_us, last, output ready);
endinterface

@@ hdl/drvs_div.sv @@
module drvs_div (
   input  logic                  clock,
   input  logic                  reset,
   input  drvs_pkg::div_req_type div_req,
   output drvs_pkg::div_rsp_type div_rsp
);
   import drvs_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [VOLT_W-1:0]    qd_ff, qd_in;
   logic [SLEW_W-1:0]    rem_ff, rem_in;
   logic [SLEW_W-1:0]    dvs_ff, dvs_in;
   logic [SLEW_W:0]      shifted;
   logic [SLEW_W:0]      trial;
   logic                 fits;

   assign shifted = {rem_ff, qd_ff[VOLT_W-1]};
   assign trial   = shifted - {1'b0, dvs_ff};
   assign fits    = shifted >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      qd_in   = qd_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(VOLT_W - 1);
         qd_in   = div_req.dividend;
         rem_in  = '0;
         dvs_in  = div_req.divisor;
      end else if (busy_ff) begin
         // shift one quotient bit per cycle
         rem_in = fits ? trial[SLEW_W-1:0] : shifted[SLEW_W-1:0];
         qd_in  = {qd_ff[VOLT_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      qd_ff  <= qd_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.done   = done_ff;
   assign div_rsp.quot   = qd_ff;
   assign div_rsp.rem_nz = |rem_ff;

endmodule

@@ hdl/drvs_ctl.sv @@
module drvs_ctl (
   input  logic                  clock,
   input  logic                  reset,
   input  drvs_pkg::cfg_type     cfg,
   drvs_req_if.sink              req_bus,
   drvs_rsp_if.source            rsp_bus,
   output drvs_pkg::div_req_type div_req,
   input  drvs_pkg::div_rsp_type div_rsp
);
   import drvs_pkg::*;

   ctl_state_type     state_ff, state_in;
   step_type          step_ff, step_in;
   logic [VOLT_W-1:0] tmin_ff, tmin_in;
   logic [VOLT_W-1:0] tmax_ff, tmax_in;
   logic [VOLT_W-1:0] core_volt_ff, core_volt_in;
   logic [VOLT_W-1:0] supply_volt_ff, supply_volt_in;
   logic              sup_ff, sup_in;
   logic              cross_ff, cross_in;
   logic [VOLT_W-1:0] sup_old_ff, sup_old_in;
   logic [VOLT_W-1:0] sup_new_ff, sup_new_in;
   logic              cmd_rail_ff, cmd_rail_in;
   logic [VOLT_W-1:0] cmd_min_ff, cmd_min_in;
   logic [VOLT_W-1:0] cmd_max_ff, cmd_max_in;
   logic [VOLT_W-1:0] cmd_old_ff, cmd_old_in;
   logic              cmd_last_ff, cmd_last_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_rail_ff, rsp_rail_in;
   logic [VOLT_W-1:0] rsp_min_ff, rsp_min_in;
   logic [VOLT_W-1:0] rsp_max_ff, rsp_max_in;
   logic [VOLT_W-1:0] rsp_wait_ff, rsp_wait_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              out_free;
   logic              load_out;
   logic              start;
   logic              req_ready;
   logic              pl_pre, pl_sup, pl_cross;
   logic [VOLT_W-1:0] pl_old, pl_new;
   logic              ld_rail, ld_clamp, ld_last;
   logic [VOLT_W-1:0] ld_min, ld_max, ld_old;
   logic              rising, falling;
   logic [VOLT_W:0]   ceil_q;
   logic [VOLT_W:0]   wait_sum;
   logic [VOLT_W-1:0] wait_val;

   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_bus.valid) state_in = ST_PLAN;
         ST_PLAN:  state_in = ST_LOAD;
         ST_LOAD:  state_in = ST_START;
         ST_START: state_in = ST_DIV;
         ST_DIV:   if (div_rsp.done) state_in = ST_OUT;
         ST_OUT:   if (out_free) state_in = cmd_last_ff ? ST_IDLE : ST_LOAD;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      start     = 1'b0;
      load_out  = 1'b0;
      unique case (state_ff)
         ST_IDLE:  req_ready = 1'b1;
         ST_START: start = 1'b1;
         ST_OUT:   load_out = out_free;
         default:  ;
      endcase
   end

   // plan the supply move and the pre-move of the core
   always_comb begin
      pl_pre   = 1'b0;
      pl_sup   = 1'b0;
      pl_cross = 1'b0;
      pl_old   = supply_volt_ff;
      pl_new   = cfg.trans_next_uv;
      if (cfg.supply_present) begin
         if (tmin_ff > cfg.trans_uv && core_volt_ff > cfg.trans_uv) begin
            pl_sup = supply_volt_ff < cfg.trans_next_uv;
         end else if (tmin_ff <= cfg.trans_uv && core_volt_ff <= cfg.trans_uv) begin
            pl_sup = supply_volt_ff >= cfg.trans_next_uv;
            pl_new = cfg.trans_uv;
         end else if (tmin_ff > cfg.trans_uv) begin
            pl_pre   = core_volt_ff < cfg.trans_uv;
            pl_sup   = 1'b1;
            pl_cross = 1'b1;
            pl_old   = cfg.trans_uv;
         end else begin
            pl_pre   = 1'b1;
            pl_sup   = 1'b1;
            pl_cross = 1'b1;
            pl_old   = cfg.trans_next_uv;
            pl_new   = cfg.trans_uv;
         end
      end
   end

   // build the command of the current step
   always_comb begin
      ld_rail  = 1'b0;
      ld_clamp = 1'b1;
      ld_last  = 1'b0;
      ld_min   = cfg.trans_uv;
      ld_max   = cfg.trans_uv;
      ld_old   = core_volt_ff;
      case (step_ff)
         STEP_SUP: begin
            ld_rail  = 1'b1;
            ld_clamp = 1'b0;
            ld_min   = sup_new_ff;
            ld_max   = sup_new_ff;
            ld_old   = sup_old_ff;
         end
         STEP_CORE: begin
            ld_last = 1'b1;
            ld_min  = tmin_ff;
            ld_max  = tmax_ff;
            ld_old  = cross_ff ? cfg.trans_uv : core_volt_ff;
         end
         default: ;
      endcase
      if (ld_clamp && cfg.core_floor_uv > ld_min) begin
         ld_min = cfg.core_floor_uv;
         ld_max = cfg.core_floor_uv;
      end
   end

   assign rising  = cmd_min_ff > cmd_old_ff;
   assign falling = cmd_min_ff < cmd_old_ff;

   always_comb begin
      div_req.start    = start;
      div_req.dividend = rising ? (cmd_min_ff - cmd_old_ff) : (cmd_old_ff - cmd_min_ff);
      if (rising && cfg.slew_up != '0) begin
         div_req.divisor = cfg.slew_up;
      end else if (falling && cfg.slew_down != '0) begin
         div_req.divisor = cfg.slew_down;
      end else begin
         div_req.divisor = SLEW_W'(1);
      end
   end

   assign ceil_q   = {1'b0, div_rsp.quot} + (VOLT_W + 1)'(div_rsp.rem_nz);
   assign wait_sum = ceil_q + (VOLT_W + 1)'(cfg.settle_base_us);
   assign wait_val = (wait_sum > {1'b0, WAIT_SAT}) ? WAIT_SAT : wait_sum[VOLT_W-1:0];

   always_comb begin
      step_in        = step_ff;
      tmin_in        = tmin_ff;
      tmax_in        = tmax_ff;
      core_volt_in   = core_volt_ff;
      supply_volt_in = supply_volt_ff;
      sup_in         = sup_ff;
      cross_in       = cross_ff;
      sup_old_in     = sup_old_ff;
      sup_new_in     = sup_new_ff;
      cmd_rail_in    = cmd_rail_ff;
      cmd_min_in     = cmd_min_ff;
      cmd_max_in     = cmd_max_ff;
      cmd_old_in     = cmd_old_ff;
      cmd_last_in    = cmd_last_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_bus.ready;
      rsp_rail_in    = rsp_rail_ff;
      rsp_min_in     = rsp_min_ff;
      rsp_max_in     = rsp_max_ff;
      rsp_wait_in    = rsp_wait_ff;
      rsp_last_in    = rsp_last_ff;

      if (req_ready && req_bus.valid) begin
         tmin_in = req_bus.target_min_uv;
         tmax_in = req_bus.target_max_uv;
      end

      if (state_ff == ST_PLAN) begin
         sup_in     = pl_sup;
         cross_in   = pl_cross;
         sup_old_in = pl_old;
         sup_new_in = pl_new;
         step_in    = pl_pre ? STEP_PRE : (pl_sup ? STEP_SUP : STEP_CORE);
      end

      if (state_ff == ST_LOAD) begin
         cmd_rail_in = ld_rail;
         cmd_min_in  = ld_min;
         cmd_max_in  = ld_max;
         cmd_old_in  = ld_old;
         cmd_last_in = ld_last;
      end

      if (load_out) begin
         rsp_valid_in = 1'b1;
         rsp_rail_in  = cmd_rail_ff;
         rsp_min_in   = cmd_min_ff;
         rsp_max_in   = cmd_max_ff;
         rsp_wait_in  = wait_val;
         rsp_last_in  = cmd_last_ff;
         if (cmd_rail_ff) begin
            supply_volt_in = cmd_min_ff;
         end else begin
            core_volt_in = cmd_min_ff;
         end
         // advance to the next step
         if (step_ff == STEP_PRE && sup_ff) begin
            step_in = STEP_SUP;
         end else begin
            step_in = STEP_CORE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         step_ff        <= STEP_CORE;
         rsp_valid_ff   <= 1'b0;
         core_volt_ff   <= '0;
         supply_volt_ff <= '0;
      end else begin
         state_ff       <= state_in;
         step_ff        <= step_in;
         rsp_valid_ff   <= rsp_valid_in;
         core_volt_ff   <= core_volt_in;
         supply_volt_ff <= supply_volt_in;
      end
   end

   always_ff @(posedge clock) begin
      tmin_ff     <= tmin_in;
      tmax_ff     <= tmax_in;
      sup_ff      <= sup_in;
      cross_ff    <= cross_in;
      sup_old_ff  <= sup_old_in;
      sup_new_ff  <= sup_new_in;
      cmd_rail_ff <= cmd_rail_in;
      cmd_min_ff  <= cmd_min_in;
      cmd_max_ff  <= cmd_max_in;
      cmd_old_ff  <= cmd_old_in;
      cmd_last_ff <= cmd_last_in;
      rsp_rail_ff <= rsp_rail_in;
      rsp_min_ff  <= rsp_min_in;
      rsp_max_ff  <= rsp_max_in;
      rsp_wait_ff <= rsp_wait_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign req_bus.ready       = req_ready;
   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.rail        = rsp_rail_ff;
   assign rsp_bus.volt_min_uv = rsp_min_ff;
   assign rsp_bus.volt_max_uv = rsp_max_ff;
   assign rsp_bus.wait_us     = rsp_wait_ff;
   assign rsp_bus.last        = rsp_last_ff;

endmodule

@@ hdl/dual_rail_voltage_sequencer_unit.sv @@
// Dual-rail voltage sequencer.
// req_bus takes one voltage request (target_min_uv, target_max_uv) per
// transaction; rsp_bus returns one to three set-voltage commands for it,
// core pre-move, supply move, final core move, in that order, the final
// one flagged with last. csr_we/csr_index/csr_wdata write the settings;
// write them only while no request is in flight.
// Each command passes through the load and start steps, the bit-serial
// slew divider (one quotient bit per cycle over 21 bits) and the output
// step. A request passes through the idle and plan states, then these
// steps once per command; req_bus.ready stays low until the last command is
// in the output register. One request is in work at a time.
// Reset clears both tracked rail voltages to 0 and loads the default
// settings. When the receiver holds rsp_bus.ready low, the finished
// command waits in the output register and the next command stalls
// before entering it.
module dual_rail_voltage_sequencer_unit (
   input  logic                             clock,
   input  logic                             reset,
   drvs_req_if.sink                         req_bus,
   drvs_rsp_if.source                       rsp_bus,
   input  logic                             csr_we,
   input  logic [drvs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [drvs_pkg::VOLT_W-1:0]      csr_wdata
);
   import drvs_pkg::*;

   cfg_type     cfg_ff, cfg_in;
   div_req_type div_req;
   div_rsp_type div_rsp;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_SUPPLY_PRESENT: cfg_in.supply_present = csr_wdata[0];
            CSR_TRANS_UV:       cfg_in.trans_uv       = csr_wdata;
            CSR_TRANS_NEXT_UV:  cfg_in.trans_next_uv  = csr_wdata;
            CSR_CORE_FLOOR_UV:  cfg_in.core_floor_uv  = csr_wdata;
            CSR_SLEW_UP:        cfg_in.slew_up        = csr_wdata[SLEW_W-1:0];
            CSR_SLEW_DOWN:      cfg_in.slew_down      = csr_wdata[SLEW_W-1:0];
            CSR_SETTLE_BASE_US: cfg_in.settle_base_us = csr_wdata[SETTLE_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.supply_present <= RST_SUPPLY;
         cfg_ff.trans_uv       <= RST_TRANS_UV;
         cfg_ff.trans_next_uv  <= RST_TRANS_NEXT_UV;
         cfg_ff.core_floor_uv  <= RST_CORE_FLOOR_UV;
         cfg_ff.slew_up        <= RST_SLEW_UP;
         cfg_ff.slew_down      <= RST_SLEW_DOWN;
         cfg_ff.settle_base_us <= RST_SETTLE_US;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   drvs_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   drvs_ctl u_ctl (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_bus.valid && req_bus.ready |=> !req_bus.ready)
      else $error("request taken while previous one in work");

   a_div_not_instant: assert property (@(posedge clock) disable iff (reset)
      div_req.start |=> !div_rsp.done)
      else $error("divider finished in one cycle");

   a_supply_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.rail |-> !rsp_bus.last)
      else $error("supply command flagged as final");

   a_wait_saturates: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> rsp_bus.wait_us <= WAIT_SAT)
      else $error("wait beyond saturation limit");

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
   import drvs_pkg::*;

   localparam int  CYCLE_LIMIT   = 400000;
   localparam int  QUIET_CYCLES  = 100;
   localparam int  HOLD_CYCLES   = 400;
   localparam int  PHASE_COUNT   = 10;
   localparam int  PHASE_ITEMS   = 26;
   localparam logic RAIL_CORE    = 1'b0;
   localparam logic RAIL_SUPPLY  = 1'b1;
   localparam logic [VOLT_W-1:0] VOLT_TOP = 21'd1500000;

   typedef struct packed {
      logic              rail;
      logic [VOLT_W-1:0] volt_min_uv;
      logic [VOLT_W-1:0] volt_max_uv;
      logic [VOLT_W-1:0] wait_us;
      logic              last;
   } rail_cmd_type;

   class rail_plan_board;
      logic                supply_present;
      logic [VOLT_W-1:0]   trans_uv;
      logic [VOLT_W-1:0]   trans_next_uv;
      logic [VOLT_W-1:0]   core_floor_uv;
      logic [SLEW_W-1:0]   slew_up;
      logic [SLEW_W-1:0]   slew_down;
      logic [SETTLE_W-1:0] settle_base_us;
      logic [VOLT_W-1:0]   core_volt;
      logic [VOLT_W-1:0]   supply_volt;
      rail_cmd_type        pending_cmds[$];
      int                  errors;

      function new();
         errors = 0;
         reset_state();
      endfunction

      function void reset_state();
         supply_present = RST_SUPPLY;
         trans_uv       = RST_TRANS_UV;
         trans_next_uv  = RST_TRANS_NEXT_UV;
         core_floor_uv  = RST_CORE_FLOOR_UV;
         slew_up        = RST_SLEW_UP;
         slew_down      = RST_SLEW_DOWN;
         settle_base_us = RST_SETTLE_US;
         core_volt      = '0;
         supply_volt    = '0;
      endfunction

      function void apply_setting(csr_idx_type idx, logic [VOLT_W-1:0] value);
         case (idx)
            CSR_SUPPLY_PRESENT: supply_present = value[0];
            CSR_TRANS_UV:       trans_uv       = value;
            CSR_TRANS_NEXT_UV:  trans_next_uv  = value;
            CSR_CORE_FLOOR_UV:  core_floor_uv  = value;
            CSR_SLEW_UP:        slew_up        = value[SLEW_W-1:0];
            CSR_SLEW_DOWN:      slew_down      = value[SLEW_W-1:0];
            CSR_SETTLE_BASE_US: settle_base_us = value[SETTLE_W-1:0];
            default: ;
         endcase
      endfunction

      function logic [VOLT_W-1:0] settle_wait(logic [VOLT_W-1:0] old_v,
                                              logic [VOLT_W-1:0] new_v);
         logic [31:0] rate;
         logic [31:0] diff;
         logic [31:0] w;
         rate = 32'd1;
         if (slew_up != '0 && new_v > old_v) begin
            rate = 32'(slew_up);
         end else if (slew_down != '0 && new_v < old_v) begin
            rate = 32'(slew_down);
         end
         diff = (new_v > old_v) ? 32'(new_v - old_v) : 32'(old_v - new_v);
         w = (diff + rate - 32'd1) / rate + 32'(settle_base_us);
         if (w > 32'(WAIT_SAT)) begin
            w = 32'(WAIT_SAT);
         end
         return w[VOLT_W-1:0];
      endfunction

      function void push_cmd(logic rail, logic [VOLT_W-1:0] vmin,
                             logic [VOLT_W-1:0] vmax, logic [VOLT_W-1:0] w);
         rail_cmd_type cmd;
         cmd.rail        = rail;
         cmd.volt_min_uv = vmin;
         cmd.volt_max_uv = vmax;
         cmd.wait_us     = w;
         cmd.last        = 1'b0;
         pending_cmds.push_back(cmd);
      endfunction

      function void add_core(logic [VOLT_W-1:0] old_v, logic [VOLT_W-1:0] vmin,
                             logic [VOLT_W-1:0] vmax);
         if (core_floor_uv > vmin) begin
            vmin = core_floor_uv;
            vmax = core_floor_uv;
         end
         push_cmd(RAIL_CORE, vmin, vmax, settle_wait(old_v, vmin));
         core_volt = vmin;
      endfunction

      function void add_supply(logic [VOLT_W-1:0] old_v, logic [VOLT_W-1:0] v);
         push_cmd(RAIL_SUPPLY, v, v, settle_wait(old_v, v));
         supply_volt = v;
      endfunction

      function void plan_request(logic [VOLT_W-1:0] tmin, logic [VOLT_W-1:0] tmax);
         logic [VOLT_W-1:0] c;
         c = core_volt;
         if (supply_present) begin
            if (tmin > trans_uv && c > trans_uv) begin
               if (supply_volt < trans_next_uv) begin
                  add_supply(supply_volt, trans_next_uv);
               end
            end else if (tmin <= trans_uv && c <= trans_uv) begin
               if (supply_volt >= trans_next_uv) begin
                  add_supply(supply_volt, trans_uv);
               end
            end else if (tmin > trans_uv) begin
               if (c < trans_uv) begin
                  add_core(c, trans_uv, trans_uv);
                  c = trans_uv;
               end
               add_supply(trans_uv, trans_next_uv);
            end else begin
               add_core(c, trans_uv, trans_uv);
               c = trans_uv;
               add_supply(trans_next_uv, trans_uv);
            end
         end
         add_core(c, tmin, tmax);
         pending_cmds[pending_cmds.size()-1].last = 1'b1;
      endfunction

      function void report(string field, logic [VOLT_W-1:0] want, logic [VOLT_W-1:0] got);
         errors++;
         $display("%0t %s mismatch: expected %0d actual %0d", $time, field, want, got);
      endfunction

      function void check_command(rail_cmd_type got);
         rail_cmd_type want;
         if (pending_cmds.size() == 0) begin
            report("unexpected command, volt_min_uv", '0, got.volt_min_uv);
            return;
         end
         want = pending_cmds.pop_front();
         if (want.rail != got.rail)
            report("rail", VOLT_W'(want.rail), VOLT_W'(got.rail));
         if (want.volt_min_uv != got.volt_min_uv)
            report("volt_min_uv", want.volt_min_uv, got.volt_min_uv);
         if (want.volt_max_uv != got.volt_max_uv)
            report("volt_max_uv", want.volt_max_uv, got.volt_max_uv);
         if (want.wait_us != got.wait_us) report("wait_us", want.wait_us, got.wait_us);
         if (want.last != got.last)
            report("last", VOLT_W'(want.last), VOLT_W'(got.last));
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [VOLT_W-1:0]    csr_wdata;

   drvs_req_if req_bus();
   drvs_rsp_if rsp_bus();

   dual_rail_voltage_sequencer_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   rail_plan_board board;
   int             sender_idle_pct;
   int             receiver_stall_pct;
   bit             hold_request;
   int             hold_left;
   int             cycle_count;

   logic [VOLT_W-1:0] next_min;
   logic [VOLT_W-1:0] next_max;
   logic [VOLT_W-1:0] pick_trans;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (hold_request) begin
         hold_left    = HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   always @(posedge clock) begin : rsp_monitor
      rail_cmd_type seen;
      seen.rail        = rsp_bus.rail;
      seen.volt_min_uv = rsp_bus.volt_min_uv;
      seen.volt_max_uv = rsp_bus.volt_max_uv;
      seen.wait_us     = rsp_bus.wait_us;
      seen.last        = rsp_bus.last;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         board.check_command(seen);
      end
   end

   task automatic send_request(input logic [VOLT_W-1:0] tmin,
                               input logic [VOLT_W-1:0] tmax);
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.target_min_uv <= tmin;
      req_bus.target_max_uv <= tmax;
      do @(posedge clock); while (!req_bus.ready);
      board.plan_request(tmin, tmax);
   endtask

   task automatic quiesce();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (board.pending_cmds.size() != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   task automatic write_setting(input csr_idx_type idx, input logic [VOLT_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      board.apply_setting(idx, value);
   endtask

   task automatic end_settings();
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic change_setting(input csr_idx_type idx, input logic [VOLT_W-1:0] value);
      quiesce();
      write_setting(idx, value);
      end_settings();
   endtask

   task automatic load_settings(input logic sp, input logic [VOLT_W-1:0] t,
                                input logic [VOLT_W-1:0] nt, input logic [VOLT_W-1:0] fl,
                                input logic [VOLT_W-1:0] su, input logic [VOLT_W-1:0] sd,
                                input logic [VOLT_W-1:0] st);
      write_setting(CSR_SUPPLY_PRESENT, {{(VOLT_W-1){1'b0}}, sp});
      write_setting(CSR_TRANS_UV, t);
      write_setting(CSR_TRANS_NEXT_UV, nt);
      write_setting(CSR_CORE_FLOOR_UV, fl);
      write_setting(CSR_SLEW_UP, su);
      write_setting(CSR_SLEW_DOWN, sd);
      write_setting(CSR_SETTLE_BASE_US, st);
      end_settings();
   endtask

   function automatic logic [VOLT_W-1:0] pick_slew();
      logic [VOLT_W-1:0] s;
      case ($urandom_range(4))
         0:       s = '0;
         1:       s = VOLT_W'(1);
         2:       s = VOLT_W'(65535);
         default: s = VOLT_W'($urandom_range(65535, 1));
      endcase
      return s;
   endfunction

   function automatic logic [VOLT_W-1:0] pick_volt();
      logic [VOLT_W-1:0] v;
      case ($urandom_range(10))
         0, 1, 2, 3: v = VOLT_W'(board.trans_uv + $urandom_range(20000) - 10000);
         4, 5:       v = VOLT_W'(board.trans_next_uv + $urandom_range(20000) - 10000);
         6, 7:       v = VOLT_W'($urandom_range(1500000));
         8:          v = $urandom_range(1) ? VOLT_TOP : '0;
         9:          v = VOLT_W'(board.core_floor_uv + $urandom_range(20000) - 10000);
         default:    v = VOLT_W'($urandom);
      endcase
      return v;
   endfunction

   initial begin
      board              = new();
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      hold_request       = 1'b0;
      hold_left          = 0;
      cycle_count        = 0;
      req_bus.valid         = 1'b0;
      req_bus.target_min_uv = '0;
      req_bus.target_max_uv = '0;
      rsp_bus.ready      = 1'b0;
      csr_we             = 1'b0;
      csr_index          = CSR_SUPPLY_PRESENT;
      csr_wdata          = '0;
      reset              = 1'b1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_request(21'd0, 21'd0);
      send_request(21'd800000, 21'd850000);
      send_request(21'd900000, 21'd900000);
      send_request(VOLT_TOP, VOLT_TOP);
      send_request(21'd700000, 21'd720000);
      send_request(21'd750000, 21'd750000);
      send_request(21'd750001, 21'd760000);
      send_request(21'd600000, 21'd100000);
      send_request(21'h1FFFFF, 21'h1FFFFF);
      send_request(21'd0, 21'h1FFFFF);
      send_request(21'h0AAAAA, 21'h155555);
      send_request(21'h155555, 21'h0AAAAA);
      change_setting(CSR_TRANS_UV, 21'd1000000);
      send_request(21'd900000, 21'd900000);
      send_request(21'd950000, 21'd960000);
      change_setting(CSR_TRANS_UV, 21'd750000);
      send_request(21'd800000, 21'd800000);
      change_setting(CSR_TRANS_NEXT_UV, 21'd1200000);
      send_request(21'd900000, 21'd910000);
      change_setting(CSR_CORE_FLOOR_UV, 21'd800000);
      send_request(21'd100000, 21'd200000);
      send_request(21'd1000000, 21'd1100000);
      change_setting(CSR_SUPPLY_PRESENT, 21'd0);
      send_request(21'd300000, 21'd400000);
      send_request(21'd1200000, 21'd1300000);

      for (int p = 0; p < PHASE_COUNT; p++) begin
         quiesce();
         case (p)
            0: load_settings(RST_SUPPLY, RST_TRANS_UV, RST_TRANS_NEXT_UV, RST_CORE_FLOOR_UV,
                             VOLT_W'(RST_SLEW_UP), VOLT_W'(RST_SLEW_DOWN),
                             VOLT_W'(RST_SETTLE_US));
            1: load_settings(1'b1, 21'd0, VOLT_TOP, 21'd0, 21'd0, 21'd0, 21'd1023);
            2: load_settings(1'b1, VOLT_TOP, 21'd0, VOLT_TOP, 21'd65535, 21'd65535, 21'd0);
            default: begin
               pick_trans = VOLT_W'($urandom_range(1500000));
               load_settings((p == 3) ? 1'b0 : ($urandom_range(3) != 0),
                             pick_trans,
                             ($urandom_range(3) != 0)
                                ? VOLT_W'(pick_trans + $urandom_range(150000))
                                : VOLT_W'($urandom_range(1500000)),
                             $urandom_range(1) ? '0 : VOLT_W'($urandom_range(1500000)),
                             pick_slew(), pick_slew(), VOLT_W'($urandom_range(1023)));
            end
         endcase
         case (p % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 86; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 86; end
            default: begin sender_idle_pct = 32; receiver_stall_pct = 32; end
         endcase
         if (p == 4) begin
            hold_request = 1'b1;
         end
         repeat (PHASE_ITEMS) begin
            next_min = pick_volt();
            case ($urandom_range(9))
               0, 1, 2, 3, 4, 5, 6: next_max = VOLT_W'(next_min + $urandom_range(50000));
               7:                   next_max = next_min;
               8:                   next_max = pick_volt();
               default:             next_max = VOLT_W'($urandom);
            endcase
            send_request(next_min, next_max);
         end
      end

      quiesce();
      if (board.errors == 0 && board.pending_cmds.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
hdl/drvs_pkg.sv
hdl/drvs_if.sv
hdl/drvs_div.sv
hdl/drvs_ctl.sv
hdl/dual_rail_voltage_sequencer_unit.sv
tb/sv/testbench.sv
